>>> rtl/core/hqc_pkg.sv
`default_nettype none
package hqc_pkg;

	// Default sizes of the histogram store.
	localparam int NUM_BINS_DEF   = 4096;
	localparam int COUNT_BITS_DEF = 32;

	// Five histogrammed variables, one RAM each.
	localparam int NVARS       = 5;
	localparam int VAR_SIEIE   = 0;
	localparam int VAR_HOE     = 1;
	localparam int VAR_ISO_PHO = 2;
	localparam int VAR_ISO_CHG = 3;
	localparam int VAR_ISO_NEU = 4;

	localparam int FIELD_W   = 16;
	localparam int CUT_W     = 13;
	localparam int TOTAL_W   = 32;
	localparam int RUN_W     = 48;
	localparam int NREGS     = 8;
	localparam int REG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;

	// Fixed-point correction constants (Q32 scaled).
	localparam longint unsigned K_PHO     = 64'd247390116;
	localparam longint unsigned K_NEU_LIN = 64'd1051407994;
	localparam longint unsigned K_NEU_SQ  = 64'd68719;
	localparam longint unsigned HALF32    = 64'h0000_0000_8000_0000;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PT_MIN      = 3'd0,
		REG_PT_MAX      = 3'd1,
		REG_SCALE_SIEIE = 3'd2,
		REG_SCALE_HOE   = 3'd3,
		REG_SCALE_ISO_P = 3'd4,
		REG_SCALE_ISO_C = 3'd5,
		REG_SCALE_ISO_N = 3'd6,
		REG_QUANT_FRAC  = 3'd7
	} cfg_reg_t;

	localparam logic [FIELD_W-1:0] REG_RESET [NREGS] = '{
		16'd320, 16'd3200, 16'd8192, 16'd8192, 16'd5115, 16'd4112, 16'd13981, 16'd65529
	};

	// Item opcodes.
	typedef enum logic {
		OP_EVENT  = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EV_WR,
		BK_FIN_MUL,
		BK_SCAN,
		BK_FIN_OUT
	} bk_state_t;

endpackage
`default_nettype wire

>>> rtl/core/hqc_in_if.sv
`default_nettype none
interface hqc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] pt;
	logic [15:0] hoe;
	logic [15:0] sieie;
	logic [15:0] iso_photon;
	logic [15:0] iso_charged;
	logic [15:0] iso_neutral;

	modport source (output valid, opcode, pt, hoe, sieie, iso_photon, iso_charged,
		iso_neutral, input ready);
	modport sink (input valid, opcode, pt, hoe, sieie, iso_photon, iso_charged,
		iso_neutral, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hqc_out_if.sv
`default_nettype none
interface hqc_out_if;
	logic        valid;
	logic        ready;
	logic [12:0] cut_bin_sieie;
	logic [12:0] cut_bin_hoe;
	logic [12:0] cut_bin_iso_photon;
	logic [12:0] cut_bin_iso_charged;
	logic [12:0] cut_bin_iso_neutral;
	logic [31:0] accepted_events;

	modport source (output valid, cut_bin_sieie, cut_bin_hoe, cut_bin_iso_photon,
		cut_bin_iso_charged, cut_bin_iso_neutral, accepted_events, input ready);
	modport sink (input valid, cut_bin_sieie, cut_bin_hoe, cut_bin_iso_photon,
		cut_bin_iso_charged, cut_bin_iso_neutral, accepted_events, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hqc_cfg_if.sv
`default_nettype none
interface hqc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/histogram_quantile_cuts.sv
// Channel   Dir  Handshake      Payload
// din       in   valid/ready    opcode, pt, hoe, sieie, iso_photon, iso_charged, iso_neutral
// dout      out  valid/ready    cut_bin_* (5 x 13 bit), accepted_events
// cfg       in   valid/ready    index (3 bit), data (16 bit)
//
// An event item passes a five stage front pipeline, then two back-end steps (RAM read,
// then increment and write); the back end takes no new item until the write is done.
// A finish item is taken from the queue, then the target product is formed, each bin is
// read in turn, the scan is drained (each bin is zeroed behind it), and the result is
// handed over once the output register is free.
// After reset a clearing pass zeroes the RAMs; din.ready stays low until it is done.
// A four entry queue between front and back lets either side stall alone.
`default_nettype none
module histogram_quantile_cuts
	import hqc_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hqc_in_if.sink     din,
	hqc_out_if.source  dout,
	hqc_cfg_if.sink    cfg
);

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int QW = 1 + NVARS * (BIN_W + 1);

	logic [FIELD_W-1:0] regs_q [NREGS];
	logic [FIELD_W-1:0] scale [NVARS];
	logic               init_done;
	logic               push, push_ready, pop, head_valid;
	logic [QW-1:0]      push_data, head_data;
	logic [CUT_W-1:0]   cut_bin [NVARS];

	// Configuration registers; writes are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REG_RESET;
		end else if (cfg.valid) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	assign scale[VAR_SIEIE]   = regs_q[REG_SCALE_SIEIE];
	assign scale[VAR_HOE]     = regs_q[REG_SCALE_HOE];
	assign scale[VAR_ISO_PHO] = regs_q[REG_SCALE_ISO_P];
	assign scale[VAR_ISO_CHG] = regs_q[REG_SCALE_ISO_C];
	assign scale[VAR_ISO_NEU] = regs_q[REG_SCALE_ISO_N];

	hqc_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (din.valid),
		.in_ready   (din.ready),
		.opcode     (din.opcode),
		.pt         (din.pt),
		.hoe        (din.hoe),
		.sieie      (din.sieie),
		.iso_photon (din.iso_photon),
		.iso_charged(din.iso_charged),
		.iso_neutral(din.iso_neutral),
		.init_done  (init_done),
		.pt_min     (regs_q[REG_PT_MIN]),
		.pt_max     (regs_q[REG_PT_MAX]),
		.scale      (scale),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	hqc_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	hqc_back #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.init_done (init_done),
		.frac      (regs_q[REG_QUANT_FRAC]),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cut_bin   (cut_bin),
		.accepted  (dout.accepted_events)
	);

	assign dout.cut_bin_sieie       = cut_bin[VAR_SIEIE];
	assign dout.cut_bin_hoe         = cut_bin[VAR_HOE];
	assign dout.cut_bin_iso_photon  = cut_bin[VAR_ISO_PHO];
	assign dout.cut_bin_iso_charged = cut_bin[VAR_ISO_CHG];
	assign dout.cut_bin_iso_neutral = cut_bin[VAR_ISO_NEU];

endmodule
`default_nettype wire

>>> rtl/core/hqc_ram.sv
`default_nettype none
module hqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/hqc_queue.sv
`default_nettype none
module hqc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q < CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count exceeds depth");

endmodule
`default_nettype wire

>>> rtl/core/hqc_front.sv
`default_nettype none
module hqc_front
	import hqc_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF,
	localparam int BIN_W = $clog2(NUM_BINS),
	localparam int QW = 1 + NVARS * (BIN_W + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [FIELD_W-1:0] pt,
	input  logic [FIELD_W-1:0] hoe,
	input  logic [FIELD_W-1:0] sieie,
	input  logic [FIELD_W-1:0] iso_photon,
	input  logic [FIELD_W-1:0] iso_charged,
	input  logic [FIELD_W-1:0] iso_neutral,
	input  logic               init_done,
	input  logic [FIELD_W-1:0] pt_min,
	input  logic [FIELD_W-1:0] pt_max,
	input  logic [FIELD_W-1:0] scale [NVARS],
	output logic               push,
	output logic [QW-1:0]      push_data,
	input  logic               push_ready
);

	logic advance;
	logic accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// Stage 1: window test and first products.
	logic               op_s1, win_s1;
	logic [FIELD_W-1:0] hoe_s1, sieie_s1, isop_s1, isoc_s1, ison_s1;
	logic [43:0]        p_pho_s1;
	logic [45:0]        p_lin_s1;
	logic [31:0]        p_sq_s1;
	// Stage 2: quadratic term and photon correction.
	logic               op_s2, win_s2;
	logic [FIELD_W-1:0] hoe_s2, sieie_s2, isop_s2, isoc_s2, ison_s2;
	logic [11:0]        corr_p_s2;
	logic [45:0]        p_lin_s2;
	logic [48:0]        p_sq2_s2;
	// Stage 3: neutral correction and corrected photon isolation.
	logic               op_s3, win_s3;
	logic [FIELD_W-1:0] hoe_s3, sieie_s3, isop_s3, isoc_s3, ison_s3;
	logic [17:0]        corr_n_s3;
	logic [49:0]        neu_sum;
	// Stage 4: corrected neutral isolation.
	logic               op_s4, win_s4;
	logic [FIELD_W-1:0] val_s4 [NVARS];
	// Stage 5: bin products.
	logic               op_s5, win_s5;
	logic [31:0]        prod_s5 [NVARS];

	assign advance  = !vld_s5 || push_ready;
	assign in_ready = advance && init_done;
	assign accept   = in_valid && in_ready;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign neu_sum = 50'(p_lin_s2) + 50'(p_sq2_s2) + 50'(HALF32);

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1    <= opcode;
			win_s1   <= (pt >= pt_min) && (pt <= pt_max);
			hoe_s1   <= hoe;
			sieie_s1 <= sieie;
			isop_s1  <= iso_photon;
			isoc_s1  <= iso_charged;
			ison_s1  <= iso_neutral;
			p_pho_s1 <= 44'(pt) * 44'(K_PHO);
			p_lin_s1 <= 46'(pt) * 46'(K_NEU_LIN);
			p_sq_s1  <= 32'(pt) * 32'(pt);

			op_s2     <= op_s1;
			win_s2    <= win_s1;
			hoe_s2    <= hoe_s1;
			sieie_s2  <= sieie_s1;
			isop_s2   <= isop_s1;
			isoc_s2   <= isoc_s1;
			ison_s2   <= ison_s1;
			corr_p_s2 <= 12'((p_pho_s1 + 44'(HALF32)) >> 32);
			p_lin_s2  <= p_lin_s1;
			p_sq2_s2  <= 49'(p_sq_s1) * 49'(K_NEU_SQ);

			op_s3     <= op_s2;
			win_s3    <= win_s2;
			hoe_s3    <= hoe_s2;
			sieie_s3  <= sieie_s2;
			isoc_s3   <= isoc_s2;
			ison_s3   <= ison_s2;
			corr_n_s3 <= neu_sum[49:32];
			isop_s3   <= (isop_s2 > {4'd0, corr_p_s2}) ?
				isop_s2 - {4'd0, corr_p_s2} : '0;

			op_s4  <= op_s3;
			win_s4 <= win_s3;
			val_s4[VAR_SIEIE]   <= sieie_s3;
			val_s4[VAR_HOE]     <= hoe_s3;
			val_s4[VAR_ISO_PHO] <= isop_s3;
			val_s4[VAR_ISO_CHG] <= isoc_s3;
			val_s4[VAR_ISO_NEU] <= (18'(ison_s3) > corr_n_s3) ?
				16'(18'(ison_s3) - corr_n_s3) : '0;

			op_s5  <= op_s4;
			win_s5 <= win_s4;
			for (int v = 0; v < NVARS; v++) begin
				prod_s5[v] <= 32'(val_s4[v]) * 32'(scale[v]);
			end
		end
	end

	// Bin index and overflow test, packed into one queue item.
	always_comb begin
		push_data = '0;
		push_data[QW-1] = op_s5;
		for (int v = 0; v < NVARS; v++) begin
			push_data[v*BIN_W +: BIN_W] = prod_s5[v][16 +: BIN_W];
			push_data[NVARS*BIN_W + v] = ({16'd0, prod_s5[v][31:16]} < 32'(NUM_BINS));
		end
	end

	// Events outside the pt window are dropped here.
	assign push = vld_s5 && push_ready && ((op_s5 == OP_FINISH) || win_s5);

endmodule
`default_nettype wire

>>> rtl/core/hqc_back.sv
`default_nettype none
module hqc_back
	import hqc_pkg::*;
#(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int BIN_W = $clog2(NUM_BINS),
	localparam int CW = $clog2(NUM_BINS + 1),
	localparam int QW = 1 + NVARS * (BIN_W + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  logic [QW-1:0]      head_data,
	output logic               pop,
	output logic               init_done,
	input  logic [FIELD_W-1:0] frac,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CUT_W-1:0]   cut_bin [NVARS],
	output logic [TOTAL_W-1:0] accepted
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [RUN_W-1:0]      RUN_MAX = {RUN_W{1'b1}};

	bk_state_t state_q, state_n;

	logic [CW-1:0]         addr_q;
	logic                  pend_q;
	logic [BIN_W-1:0]      pidx_q;
	logic [BIN_W-1:0]      ev_addr_q [NVARS];
	logic [NVARS-1:0]      ev_ok_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [RUN_W-1:0]      target_q;
	logic [RUN_W-1:0]      run_q [NVARS];
	logic [NVARS-1:0]      found_q;
	logic [CUT_W-1:0]      cut_q [NVARS];
	logic                  out_valid_q;
	logic [CUT_W-1:0]      out_cut_q [NVARS];
	logic [TOTAL_W-1:0]    out_total_q;

	logic                  ram_we    [NVARS];
	logic [BIN_W-1:0]      ram_waddr [NVARS];
	logic [COUNT_BITS-1:0] ram_wdata [NVARS];
	logic [BIN_W-1:0]      ram_raddr [NVARS];
	logic [COUNT_BITS-1:0] ram_rdata [NVARS];

	logic                  scan_issue;
	logic                  out_free;
	logic [RUN_W-1:0]      run_n [NVARS];
	logic [RUN_W:0]        run_sum [NVARS];
	logic [NVARS-1:0]      hit;
	logic [CUT_W-1:0]      pidx_cut;

	assign init_done  = (state_q != BK_CLEAR);
	assign scan_issue = (addr_q < CW'(NUM_BINS));
	assign out_free   = !out_valid_q || out_ready;
	assign pidx_cut   = CUT_W'(32'(pidx_q) + 32'd1);

	// One histogram RAM per variable.
	for (genvar v = 0; v < NVARS; v++) begin : g_ram
		hqc_ram #(
			.WIDTH(COUNT_BITS),
			.DEPTH(NUM_BINS)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[v]),
			.waddr(ram_waddr[v]),
			.wdata(ram_wdata[v]),
			.raddr(ram_raddr[v]),
			.rdata(ram_rdata[v])
		);
	end

	// Running sums for the scan, saturated at the 48 bit limit.
	always_comb begin
		for (int v = 0; v < NVARS; v++) begin
			run_sum[v] = (RUN_W + 1)'(run_q[v]) + (RUN_W + 1)'(ram_rdata[v]);
			run_n[v]   = run_sum[v][RUN_W] ? RUN_MAX : run_sum[v][RUN_W-1:0];
			hit[v]     = !found_q[v] && ({run_n[v], 16'd0} > {16'd0, target_q});
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and RAM port control.
	always_comb begin
		state_n = state_q;
		pop     = 1'b0;
		for (int v = 0; v < NVARS; v++) begin
			ram_we[v]    = 1'b0;
			ram_waddr[v] = addr_q[BIN_W-1:0];
			ram_wdata[v] = '0;
			ram_raddr[v] = addr_q[BIN_W-1:0];
		end
		unique case (state_q)
			BK_CLEAR: begin
				for (int v = 0; v < NVARS; v++) begin
					ram_we[v] = 1'b1;
				end
				if (addr_q == CW'(NUM_BINS - 1)) begin
					state_n = BK_IDLE;
				end
			end
			BK_IDLE: begin
				for (int v = 0; v < NVARS; v++) begin
					ram_raddr[v] = head_data[v*BIN_W +: BIN_W];
				end
				if (head_valid) begin
					pop = 1'b1;
					state_n = (head_data[QW-1] == OP_FINISH) ? BK_FIN_MUL : BK_EV_WR;
				end
			end
			BK_EV_WR: begin
				for (int v = 0; v < NVARS; v++) begin
					ram_we[v]    = ev_ok_q[v];
					ram_waddr[v] = ev_addr_q[v];
					ram_wdata[v] = (ram_rdata[v] == CNT_MAX) ? ram_rdata[v] :
						ram_rdata[v] + 1'b1;
				end
				state_n = BK_IDLE;
			end
			BK_FIN_MUL: begin
				state_n = BK_SCAN;
			end
			BK_SCAN: begin
				for (int v = 0; v < NVARS; v++) begin
					ram_we[v]    = pend_q;
					ram_waddr[v] = pidx_q;
				end
				if (!scan_issue && !pend_q) begin
					state_n = BK_FIN_OUT;
				end
			end
			BK_FIN_OUT: begin
				if (out_free) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_CLEAR;
		endcase
	end

	// Result valid: raised by the finish step, dropped when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_FIN_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Control registers: sweep counter and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			pend_q      <= 1'b0;
			total_q     <= '0;
		end else begin
			unique case (state_q)
				BK_CLEAR: begin
					addr_q <= addr_q + 1'b1;
				end
				BK_IDLE: begin
					if (head_valid && head_data[QW-1] == OP_EVENT && total_q != '1) begin
						total_q <= total_q + 1'b1;
					end
				end
				BK_FIN_MUL: begin
					addr_q <= '0;
					pend_q <= 1'b0;
				end
				BK_SCAN: begin
					pend_q <= scan_issue;
					if (scan_issue) begin
						addr_q <= addr_q + 1'b1;
					end
				end
				BK_FIN_OUT: begin
					if (out_free) begin
						total_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers for events and the cumulative scan.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				for (int v = 0; v < NVARS; v++) begin
					ev_addr_q[v] <= head_data[v*BIN_W +: BIN_W];
				end
				ev_ok_q <= head_data[NVARS*BIN_W +: NVARS];
			end
			BK_FIN_MUL: begin
				target_q <= 48'(frac) * 48'(total_q);
				found_q  <= '0;
				for (int v = 0; v < NVARS; v++) begin
					run_q[v] <= '0;
					cut_q[v] <= '0;
				end
			end
			BK_SCAN: begin
				pidx_q <= addr_q[BIN_W-1:0];
				if (pend_q) begin
					for (int v = 0; v < NVARS; v++) begin
						run_q[v] <= run_n[v];
						if (hit[v]) begin
							found_q[v] <= 1'b1;
							cut_q[v]   <= pidx_cut;
						end
					end
				end
			end
			BK_FIN_OUT: begin
				if (out_free) begin
					out_cut_q   <= cut_q;
					out_total_q <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign cut_bin   = out_cut_q;
	assign accepted  = out_total_q;

	a_ev_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_EV_WR |-> $past(state_q) == BK_IDLE)
		else $error("histogram write without a preceding read");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == BK_FIN_OUT)
		else $error("result raised outside the finish step");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLEAR |-> !pop)
		else $error("item taken during the clearing pass");

endmodule
`default_nettype wire
